[rtl/csq_pkg.sv]
// Shared types and constants of the counting semaphore with wait queue.
`default_nettype none
package csq_pkg;

  // Width of the signed unit count
  localparam int COUNT_W = 10;
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 10'sd255;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 10'sh200;
  // One unit, for count steps
  localparam logic signed [COUNT_W-1:0] COUNT_STEP = 10'sd1;

  // Commands
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_BLOCKED  = 3'd1;
  localparam logic [2:0] ST_OWNER    = 3'd2;
  localparam logic [2:0] ST_WOKEN    = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // Register index of initial_count
  localparam logic REG_INITIAL_COUNT = 1'b0;

  // One result item
  typedef struct packed {
    logic [2:0] status;
    logic       block_task;
    logic       wake_valid;
    logic [7:0] wake_task;
    logic [7:0] waiting_now;
  } result_t;

endpackage
`default_nettype wire

[rtl/csq_wait_mem.sv]
// Wait queue storage: one write port, one registered read port.
`default_nettype none
module csq_wait_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/csq_core.sv]
// Semaphore state, wait queue pointers and the per-request update.
`default_nettype none
module csq_core #(
  parameter int WAIT_DEPTH = 128
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire logic [7:0]       load_value,
  input  wire logic             start,
  input  wire logic             command,
  input  wire logic [7:0]       task_id,
  input  wire logic             out_free,
  output logic                  busy,
  output logic                  done,
  output csq_pkg::result_t      result
);

  localparam int PTR_W = $clog2(WAIT_DEPTH);
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WAIT_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WAIT_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  // Semaphore state
  logic signed [csq_pkg::COUNT_W-1:0] avail_count, avail_count_next;
  logic                               owner_valid, owner_valid_next;
  logic [7:0]                         owner_task, owner_task_next;
  logic [CNT_W-1:0]                   waiter_count, waiter_count_next;
  logic [PTR_W-1:0]                   head_pointer, head_pointer_next;
  logic [PTR_W-1:0]                   tail_pointer, tail_pointer_next;

  // Latched request
  logic       cmd_q;
  logic [7:0] task_q;

  logic        enq;
  logic [7:0]  head_data;
  logic [31:0] waiting_wide;
  logic signed [csq_pkg::COUNT_W-1:0] dec, inc;

  assign busy = (state == S_EXEC);
  assign done = busy && out_free;

  csq_wait_mem #(
    .DEPTH  (WAIT_DEPTH),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk   (clk),
    .we    (done && enq),
    .waddr (tail_pointer),
    .wdata (task_q),
    .re    (start),
    .raddr (head_pointer),
    .rdata (head_data)
  );

  // Saturating count steps
  assign dec = (avail_count > csq_pkg::COUNT_MIN) ? avail_count - csq_pkg::COUNT_STEP
                                                  : avail_count;
  assign inc = (avail_count < csq_pkg::COUNT_MAX) ? avail_count + csq_pkg::COUNT_STEP
                                                  : csq_pkg::COUNT_MAX;

  // Request decision
  always_comb begin
    avail_count_next  = avail_count;
    owner_valid_next  = owner_valid;
    owner_task_next   = owner_task;
    waiter_count_next = waiter_count;
    head_pointer_next = head_pointer;
    tail_pointer_next = tail_pointer;
    enq               = 1'b0;
    result.status     = csq_pkg::ST_RELEASED;
    result.block_task = 1'b0;
    result.wake_valid = 1'b0;
    result.wake_task  = 8'd0;
    if (cmd_q == csq_pkg::CMD_ACQUIRE) begin
      if (owner_valid && task_q == owner_task) begin
        result.status = csq_pkg::ST_OWNER;
      end else if (dec < 0 && owner_valid) begin
        if (waiter_count >= CNT_FULL) begin
          result.status = csq_pkg::ST_FULL;
        end else begin
          enq               = 1'b1;
          tail_pointer_next = (tail_pointer == PTR_LAST) ? '0 : tail_pointer + 1'b1;
          waiter_count_next = waiter_count + 1'b1;
          avail_count_next  = dec;
          result.status     = csq_pkg::ST_BLOCKED;
          result.block_task = 1'b1;
        end
      end else begin
        avail_count_next = dec;
        owner_valid_next = 1'b1;
        owner_task_next  = task_q;
        result.status    = csq_pkg::ST_GRANTED;
      end
    end else begin
      avail_count_next = inc;
      if (inc <= 0 && waiter_count != '0) begin
        head_pointer_next = (head_pointer == PTR_LAST) ? '0 : head_pointer + 1'b1;
        waiter_count_next = waiter_count - 1'b1;
        owner_valid_next  = 1'b1;
        owner_task_next   = head_data;
        result.status     = csq_pkg::ST_WOKEN;
        result.wake_valid = 1'b1;
        result.wake_task  = head_data;
      end
    end
    result.waiting_now = waiting_wide[7:0];
  end

  assign waiting_wide = 32'(waiter_count_next);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_EXEC;
        S_EXEC: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q  <= command;
      task_q <= task_id;
    end
  end

  // State update; a register write reloads the semaphore
  always_ff @(posedge clk) begin
    if (rst || load) begin
      avail_count  <= signed'({2'b00, (rst ? 8'd1 : load_value)});
      owner_valid  <= 1'b0;
      owner_task   <= 8'd0;
      waiter_count <= '0;
      head_pointer <= '0;
      tail_pointer <= '0;
    end else if (done) begin
      avail_count  <= avail_count_next;
      owner_valid  <= owner_valid_next;
      owner_task   <= owner_task_next;
      waiter_count <= waiter_count_next;
      head_pointer <= head_pointer_next;
      tail_pointer <= tail_pointer_next;
    end
  end

endmodule
`default_nettype wire

[rtl/counting_semaphore_wait_queue.sv]
// Top level: request and result channels, register port, output register.
//
//   channel   direction  handshake          payload
//   request   in         in_valid/in_stall  command, task_id
//   result    out        out_valid/out_stall status, block_task, wake_valid,
//                                           wake_task, waiting_now
//   config    in         APB write/read     initial_count at byte address 0
//
// A request is accepted in the idle state, which reads the queue head from the
// wait memory; the execute state updates the state and loads the output register.
// The execute state waits while the output register holds an untaken result.
// Synchronous reset loads a count of 1, no owner and an empty queue; no clearing pass.
// A stalled result holds; a new request is accepted while it waits.
`default_nettype none
module counting_semaphore_wait_queue #(
  parameter int WAIT_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [7:0]  task_id,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic             block_task,
  output logic             wake_valid,
  output logic [7:0]       wake_task,
  output logic [7:0]       waiting_now,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic              initial_count;
  logic [7:0]        init_count;
  logic              reg_wr;
  logic              start;
  logic              busy;
  logic              done;
  logic              out_free;
  csq_pkg::result_t  res;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == csq_pkg::REG_INITIAL_COUNT);
  assign initial_count = (paddr[2] == csq_pkg::REG_INITIAL_COUNT);

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      init_count <= 8'd1;
    end else if (reg_wr) begin
      init_count <= pwdata[7:0];
    end
  end

  assign prdata = initial_count ? {24'd0, init_count} : 32'd0;

  // Request transfer
  assign in_stall = busy;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  csq_core #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .load       (reg_wr),
    .load_value (pwdata[7:0]),
    .start      (start),
    .command    (command),
    .task_id    (task_id),
    .out_free   (out_free),
    .busy       (busy),
    .done       (done),
    .result     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status      <= res.status;
      block_task  <= res.block_task;
      wake_valid  <= res.wake_valid;
      wake_task   <= res.wake_task;
      waiting_now <= res.waiting_now;
    end
  end

  // Checks
  a_block_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (block_task == (status == csq_pkg::ST_BLOCKED)))
    else $error("block_task does not match status");

  a_wake_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wake_valid == (status == csq_pkg::ST_WOKEN)))
    else $error("wake_valid does not match status");

  a_wake_task_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != csq_pkg::ST_WOKEN) |-> (wake_task == 8'd0))
    else $error("wake_task set without a wake-up");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in progress");

endmodule
`default_nettype wire
